### sv/bbc_pkg.sv
`timescale 1ns / 1ps

package bbc_pkg;

   localparam int ENTRIES = 32;
   localparam int BUCKETS = 13;

   localparam int OP_W = 2;
   localparam int DEV_W = 16;
   localparam int BLK_W = 32;
   localparam int SLOT_W = 5;
   localparam int TICK_W = 32;
   localparam int STATUS_W = 2;
   localparam int REF_W = 8;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int MOD_DIGIT_W = 4;
   localparam int MOD_STEPS = BLK_W / MOD_DIGIT_W;
   localparam int NIB_W = $clog2(MOD_STEPS);

   localparam logic [REF_W-1:0] REF_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_GET,
      OP_RELEASE,
      OP_PIN,
      OP_UNPIN
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_NO_BUFFER,
      ST_UNDERFLOW
   } status_type;

   typedef struct packed {
      logic [DEV_W-1:0] device;
      logic [BLK_W-1:0] block;
      logic [BKT_W-1:0] bucket;
   } tag_word_type;

   typedef struct packed {
      logic [REF_W-1:0]  refs;
      logic [TICK_W-1:0] tick;
      logic              valid;
   } use_word_type;

   typedef struct packed {
      logic req_ready;
      logic mod_step;
      logic scan_step;
      logic get_commit;
      logic slot_read;
      logic slot_commit;
      logic push;
   } bbc_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_get;
      logic mod_done;
      logic scan_last;
      logic rsp_free;
   } bbc_stat_type;

   function automatic logic [BKT_W-1:0] mod_step(input logic [BKT_W-1:0] rem,
                                                 input logic [MOD_DIGIT_W-1:0] digit);
      logic [BKT_W+MOD_DIGIT_W-1:0] acc;
      acc = {rem, digit};
      for (int k = MOD_DIGIT_W - 1; k >= 0; k--) begin
         if (acc >= (BKT_W+MOD_DIGIT_W)'(BUCKETS << k)) begin
            acc = acc - (BKT_W+MOD_DIGIT_W)'(BUCKETS << k);
         end
      end
      return acc[BKT_W-1:0];
   endfunction

   function automatic logic in_window(input logic [BKT_W-1:0] home,
                                      input logic [BKT_W-1:0] bkt);
      logic [BKT_W:0] gap;
      gap = {1'b0, bkt} + (BKT_W+1)'(BUCKETS) - {1'b0, home};
      if (gap >= (BKT_W+1)'(BUCKETS)) begin
         gap = gap - (BKT_W+1)'(BUCKETS);
      end
      return gap <= (BKT_W+1)'(BUCKETS / 2);
   endfunction

   function automatic logic [REF_W-1:0] sat_inc(input logic [REF_W-1:0] refs);
      return (refs == REF_MAX) ? refs : refs + 1'b1;
   endfunction

endpackage

### sv/bbc_req_if.sv
`timescale 1ns / 1ps

interface bbc_req_if import bbc_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [DEV_W-1:0]  device;
   logic [BLK_W-1:0]  block_number;
   logic [SLOT_W-1:0] slot;
   logic [TICK_W-1:0] now_tick;

   modport source (output valid, output operation, output device, output block_number,
                   output slot, output now_tick, input ready);
   modport sink (input valid, input operation, input device, input block_number,
                 input slot, input now_tick, output ready);

endinterface

### sv/bbc_rsp_if.sv
`timescale 1ns / 1ps

interface bbc_rsp_if import bbc_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                hit;
   logic [SLOT_W-1:0]   granted_slot;
   logic                needs_read;
   logic [REF_W-1:0]    ref_count;

   modport source (output valid, output status, output hit, output granted_slot,
                   output needs_read, output ref_count, input ready);
   modport sink (input valid, input status, input hit, input granted_slot,
                 input needs_read, input ref_count, output ready);

endinterface

### sv/bbc_ram.sv
`timescale 1ns / 1ps

module bbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bbc_ctrl.sv
`timescale 1ns / 1ps

module bbc_ctrl import bbc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  bbc_stat_type stat,
   output bbc_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_SCAN,
      S_DRAIN,
      S_GET_COMMIT,
      S_SLOT_READ,
      S_SLOT_EVAL,
      S_PUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (stat.req_valid) begin
               state_in = stat.req_get ? S_MOD : S_SLOT_READ;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_done) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_GET_COMMIT;
         end
         S_GET_COMMIT: begin
            cmd.get_commit = 1'b1;
            state_in = S_PUSH;
         end
         S_SLOT_READ: begin
            cmd.slot_read = 1'b1;
            state_in = S_SLOT_EVAL;
         end
         S_SLOT_EVAL: begin
            cmd.slot_commit = 1'b1;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (stat.rsp_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (stat.req_valid && cmd.req_ready) |=> !cmd.req_ready)
      else $error("second transfer accepted while an item is in progress");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mod_step, cmd.scan_step, cmd.get_commit, cmd.slot_read,
                cmd.slot_commit, cmd.push}))
      else $error("more than one datapath command at once");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> stat.mod_done)
      else $error("scan running before the bucket remainder is complete");

endmodule

### sv/bbc_datapath.sv
`timescale 1ns / 1ps

module bbc_datapath import bbc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  bbc_cmd_type  cmd,
   output bbc_stat_type stat,
   bbc_req_if.sink      req_chan,
   bbc_rsp_if.source    rsp_chan
);

   logic accept;

   op_type            op_ff;
   logic [DEV_W-1:0]  dev_ff;
   logic [BLK_W-1:0]  blk_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [TICK_W-1:0] now_ff;

   logic [BLK_W-1:0] shift_ff;
   logic [BKT_W-1:0] home_ff;
   logic [NIB_W-1:0] nib_ff;

   logic [IDX_W-1:0] addr_ff;
   logic [BKT_W-1:0] bkt_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] pend_idx_ff;
   logic [BKT_W-1:0] pend_bkt_ff;

   logic [ENTRIES-1:0] tag_wr_ff;
   logic [ENTRIES-1:0] use_wr_ff;
   logic               tag_ok_ff;
   logic               use_ok_ff;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] slot_idx;
   tag_word_type     tag_rd;
   use_word_type     use_rd;
   tag_word_type     tag_eff;
   use_word_type     use_eff;

   logic             match;
   logic             elig;
   logic             better;
   logic             hit_found_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   use_word_type     hit_use_ff;
   logic             vic_found_ff;
   logic [IDX_W-1:0] vic_idx_ff;
   logic [TICK_W-1:0] vic_tick_ff;

   logic             slot_ok;
   logic             tag_we;
   logic             use_we;
   logic [IDX_W-1:0] wr_idx;
   tag_word_type     tag_wd;
   use_word_type     use_wd;

   status_type        res_status_in;
   logic              res_hit_in;
   logic [SLOT_W-1:0] res_slot_in;
   logic              res_nr_in;
   logic [REF_W-1:0]  res_refs_in;
   status_type        res_status_ff;
   logic              res_hit_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic              res_nr_ff;
   logic [REF_W-1:0]  res_refs_ff;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic              rsp_hit_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_nr_ff;
   logic [REF_W-1:0]  rsp_refs_ff;

   assign req_chan.ready = cmd.req_ready;
   assign accept = req_chan.valid && cmd.req_ready;

   assign slot_idx = IDX_W'(slot_ff);
   assign slot_ok = int'(slot_ff) < ENTRIES;

   assign stat.req_valid = req_chan.valid;
   assign stat.req_get = op_type'(req_chan.operation) == OP_GET;
   assign stat.mod_done = nib_ff == NIB_W'(MOD_STEPS - 1);
   assign stat.scan_last = addr_ff == IDX_W'(ENTRIES - 1);
   assign stat.rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_type'(req_chan.operation);
         dev_ff <= req_chan.device;
         blk_ff <= req_chan.block_number;
         slot_ff <= req_chan.slot;
         now_ff <= req_chan.now_tick;
      end
   end

   // block number mod bucket count, one digit per cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         shift_ff <= req_chan.block_number;
         home_ff <= '0;
         nib_ff <= '0;
      end else if (cmd.mod_step) begin
         home_ff <= mod_step(home_ff, shift_ff[BLK_W-1 -: MOD_DIGIT_W]);
         shift_ff <= shift_ff << MOD_DIGIT_W;
         if (nib_ff != NIB_W'(MOD_STEPS - 1)) begin
            nib_ff <= nib_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= '0;
         bkt_ff <= '0;
      end else if (cmd.scan_step) begin
         addr_ff <= addr_ff + 1'b1;
         bkt_ff <= (bkt_ff == BKT_W'(BUCKETS - 1)) ? '0 : bkt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= addr_ff;
      pend_bkt_ff <= bkt_ff;
   end

   assign rd_en = cmd.scan_step || cmd.slot_read;
   assign rd_addr = cmd.scan_step ? addr_ff : slot_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         tag_wr_ff <= '0;
         use_wr_ff <= '0;
      end else begin
         pend_ff <= cmd.scan_step;
         if (tag_we) begin
            tag_wr_ff[wr_idx] <= 1'b1;
         end
         if (use_we) begin
            use_wr_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         tag_ok_ff <= tag_wr_ff[rd_addr];
         use_ok_ff <= use_wr_ff[rd_addr];
      end
   end

   bbc_ram #(
      .WIDTH($bits(tag_word_type)),
      .DEPTH(ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (wr_idx),
      .wr_data (tag_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (tag_rd)
   );

   bbc_ram #(
      .WIDTH($bits(use_word_type)),
      .DEPTH(ENTRIES)
   ) u_use_ram (
      .clock   (clock),
      .wr_en   (use_we),
      .wr_addr (wr_idx),
      .wr_data (use_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (use_rd)
   );

   // unwritten entries read as their reset contents
   always_comb begin
      tag_eff = tag_rd;
      if (!tag_ok_ff) begin
         tag_eff = '0;
         tag_eff.bucket = pend_bkt_ff;
      end
      use_eff = use_ok_ff ? use_rd : '0;
   end

   assign match = (tag_eff.bucket == home_ff) && (tag_eff.device == dev_ff)
                  && (tag_eff.block == blk_ff);
   assign elig = (use_eff.refs == '0) && in_window(home_ff, tag_eff.bucket);
   assign better = !vic_found_ff || (use_eff.tick < vic_tick_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff <= 1'b0;
         vic_found_ff <= 1'b0;
      end else if (accept) begin
         hit_found_ff <= 1'b0;
         vic_found_ff <= 1'b0;
      end else if (pend_ff) begin
         if (match) begin
            hit_found_ff <= 1'b1;
         end
         if (elig) begin
            vic_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         if (match && !hit_found_ff) begin
            hit_idx_ff <= pend_idx_ff;
            hit_use_ff <= use_eff;
         end
         if (elig && better) begin
            vic_idx_ff <= pend_idx_ff;
            vic_tick_ff <= use_eff.tick;
         end
      end
   end

   always_comb begin
      tag_we = 1'b0;
      use_we = 1'b0;
      wr_idx = slot_idx;
      tag_wd = '{device: dev_ff, block: blk_ff, bucket: home_ff};
      use_wd = use_eff;
      res_status_in = ST_OK;
      res_hit_in = 1'b0;
      res_slot_in = slot_ff;
      res_nr_in = 1'b0;
      res_refs_in = '0;
      if (cmd.get_commit) begin
         if (hit_found_ff) begin
            use_we = 1'b1;
            wr_idx = hit_idx_ff;
            use_wd = hit_use_ff;
            use_wd.refs = sat_inc(hit_use_ff.refs);
            use_wd.valid = 1'b1;
            res_hit_in = 1'b1;
            res_slot_in = SLOT_W'(hit_idx_ff);
            res_nr_in = !hit_use_ff.valid;
            res_refs_in = use_wd.refs;
         end else if (vic_found_ff) begin
            tag_we = 1'b1;
            use_we = 1'b1;
            wr_idx = vic_idx_ff;
            use_wd = '{refs: REF_W'(1), tick: vic_tick_ff, valid: 1'b1};
            res_slot_in = SLOT_W'(vic_idx_ff);
            res_nr_in = 1'b1;
            res_refs_in = REF_W'(1);
         end else begin
            res_status_in = ST_NO_BUFFER;
            res_slot_in = '0;
         end
      end else if (cmd.slot_commit && slot_ok) begin
         if (op_ff == OP_PIN) begin
            use_we = 1'b1;
            use_wd.refs = sat_inc(use_eff.refs);
            res_refs_in = use_wd.refs;
         end else if (use_eff.refs == '0) begin
            res_status_in = ST_UNDERFLOW;
         end else begin
            use_we = 1'b1;
            use_wd.refs = use_eff.refs - 1'b1;
            if (op_ff == OP_RELEASE && use_wd.refs == '0) begin
               use_wd.tick = now_ff;
            end
            res_refs_in = use_wd.refs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.get_commit || cmd.slot_commit) begin
         res_status_ff <= res_status_in;
         res_hit_ff <= res_hit_in;
         res_slot_ff <= res_slot_in;
         res_nr_ff <= res_nr_in;
         res_refs_ff <= res_refs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_status_ff <= res_status_ff;
         rsp_hit_ff <= res_hit_ff;
         rsp_slot_ff <= res_slot_ff;
         rsp_nr_ff <= res_nr_ff;
         rsp_refs_ff <= res_refs_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.hit = rsp_hit_ff;
   assign rsp_chan.granted_slot = rsp_slot_ff;
   assign rsp_chan.needs_read = rsp_nr_ff;
   assign rsp_chan.ref_count = rsp_refs_ff;

   assert property (@(posedge clock) disable iff (reset)
      (tag_wr_ff & ~use_wr_ff) == '0)
      else $error("entry tag written without its count word");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_NO_BUFFER) |->
         (!rsp_hit_ff && !rsp_nr_ff && rsp_slot_ff == '0 && rsp_refs_ff == '0))
      else $error("miss without victim carries nonzero fields");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_status_ff == ST_OK && rsp_refs_ff != '0))
      else $error("hit result with bad status or zero count");

endmodule

### sv/block_buffer_cache_directory.sv
// Directory of a disk block buffer cache with 32 entries, each holding device, block number,
// reference count, last-release tick and a valid mark, grouped in 13 buckets by block number.
// A get first reduces the block number mod 13 one hex digit per cycle, then reads the
// directory RAMs one entry per cycle to find the lowest matching entry and the least
// recently released free entry in the 7 forward buckets, drains the last read, then
// updates the entry and posts the result. Release, pin and unpin read and update the
// addressed entry. The next request is taken only once the previous one has posted its
// result; it is taken while that result still waits in the output register, and a
// result is posted only once that register is free. Directory contents are valid
// right after reset; no clearing pass is needed.
`timescale 1ns / 1ps

module block_buffer_cache_directory import bbc_pkg::*; (
   input logic       clock,
   input logic       reset,
   bbc_req_if.sink   req_chan,
   bbc_rsp_if.source rsp_chan
);

   bbc_cmd_type  cmd;
   bbc_stat_type stat;

   bbc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   bbc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
